>>> rtl/core/line_numbering_sectioner_unit_macros.svh
// Assertion macros for the line numbering sectioner unit.
`ifndef LINE_NUMBERING_SECTIONER_UNIT_MACROS_SVH
`define LINE_NUMBERING_SECTIONER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LNSU_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("lnsu: implication check failed");
`define LNSU_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("lnsu: next-cycle check failed");
`else
`define LNSU_ASSERT_IMP(label, pre, post)
`define LNSU_ASSERT_NXT(label, pre, post)
`endif
`endif

>>> rtl/core/lnsu_pkg.sv
// Types and constants shared by the line numbering sectioner unit.
package lnsu_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECTION_MODES  = 3'd0,
    REG_NUMBER_FORMAT  = 3'd1,
    REG_NUMBER_WIDTH   = 3'd2,
    REG_START_VALUE    = 3'd3,
    REG_STEP_VALUE     = 3'd4,
    REG_BLANK_GROUP    = 3'd5,
    REG_DELIMITER_PAIR = 3'd6,
    REG_SEP_FLAGS      = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEC_HEADER = 2'd0,
    SEC_BODY   = 2'd1,
    SEC_FOOTER = 2'd2
  } section_e;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_NONBLANK = 2'd1,
    MODE_ALL      = 2'd2,
    MODE_PATTERN  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FMT_RIGHT_SPACE = 2'd0,
    FMT_LEFT        = 2'd1,
    FMT_RIGHT_ZERO  = 2'd2
  } format_e;

  typedef struct packed {
    logic [5:0]  section_modes;
    logic [1:0]  number_format;
    logic [5:0]  number_width;
    logic [30:0] start_value;
    logic [30:0] step_value;
    logic [15:0] blank_group;
    logic [15:0] delimiter_pair;
    logic [8:0]  sep_flags;
  } cfg_t;

  localparam logic [5:0]  RST_SECTION_MODES  = 6'd4;
  localparam logic [1:0]  RST_NUMBER_FORMAT  = 2'd0;
  localparam logic [5:0]  RST_NUMBER_WIDTH   = 6'd6;
  localparam logic [30:0] RST_START_VALUE    = 31'd1;
  localparam logic [30:0] RST_STEP_VALUE     = 31'd1;
  localparam logic [15:0] RST_BLANK_GROUP    = 16'd1;
  localparam logic [15:0] RST_DELIMITER_PAIR = 16'h5C3A;
  localparam logic [8:0]  RST_SEP_FLAGS      = 9'd18;

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

endpackage

>>> rtl/core/lnsu_if.sv
// Input and output word channels of the line numbering sectioner unit.
interface lnsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_zero;
  logic [7:0] byte_one;
  logic [7:0] byte_two;
  logic [7:0] byte_three;
  logic [7:0] byte_four;
  logic [7:0] byte_five;
  logic [7:0] byte_six;
  logic       pattern_match;

  modport source (
    output valid, byte_zero, byte_one, byte_two, byte_three, byte_four, byte_five,
           byte_six, pattern_match,
    input  ready
  );
  modport sink (
    input  valid, byte_zero, byte_one, byte_two, byte_three, byte_four, byte_five,
           byte_six, pattern_match,
    output ready
  );
endinterface

interface lnsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       drop_line;
  logic       last_of_line;

  modport source (
    output valid, out_char, drop_line, last_of_line,
    input  ready
  );
  modport sink (
    input  valid, out_char, drop_line, last_of_line,
    output ready
  );
endinterface

>>> rtl/core/lnsu_cfg_regs.sv
// Configuration register file of the line numbering sectioner unit.
module lnsu_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lnsu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lnsu_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output lnsu_pkg::cfg_t                   cfg_o
);
  import lnsu_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.section_modes  <= RST_SECTION_MODES;
      cfg_q.number_format  <= RST_NUMBER_FORMAT;
      cfg_q.number_width   <= RST_NUMBER_WIDTH;
      cfg_q.start_value    <= RST_START_VALUE;
      cfg_q.step_value     <= RST_STEP_VALUE;
      cfg_q.blank_group    <= RST_BLANK_GROUP;
      cfg_q.delimiter_pair <= RST_DELIMITER_PAIR;
      cfg_q.sep_flags      <= RST_SEP_FLAGS;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SECTION_MODES:  cfg_q.section_modes  <= cfg_wdata_i[5:0];
        REG_NUMBER_FORMAT:  cfg_q.number_format  <= cfg_wdata_i[1:0];
        REG_NUMBER_WIDTH:   cfg_q.number_width   <= cfg_wdata_i[5:0];
        REG_START_VALUE:    cfg_q.start_value    <= cfg_wdata_i[30:0];
        REG_STEP_VALUE:     cfg_q.step_value     <= cfg_wdata_i[30:0];
        REG_BLANK_GROUP:    cfg_q.blank_group    <= cfg_wdata_i[15:0];
        REG_DELIMITER_PAIR: cfg_q.delimiter_pair <= cfg_wdata_i[15:0];
        REG_SEP_FLAGS:      cfg_q.sep_flags      <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/lnsu_div10.sv
// Shared divide-by-ten unit: registered reciprocal multiply, then quotient and digit.
module lnsu_div10 (
  input  logic        clk_i,
  input  logic [31:0] value_i,
  output logic [31:0] quot_o,
  output logic [3:0]  rem_o
);
  import lnsu_pkg::*;

  logic [63:0] prod_q;
  logic [31:0] val_q;
  logic [31:0] quot;
  logic [31:0] quot_x10;
  logic [31:0] rem_full;

  always_ff @(posedge clk_i) begin
    prod_q <= {32'd0, value_i} * {32'd0, DIV10_MAGIC};
    val_q  <= value_i;
  end

  always_comb begin
    quot     = 32'(prod_q >> DIV10_SHIFT);
    quot_x10 = (quot << 3) + (quot << 1);
    rem_full = val_q - quot_x10;
  end

  assign quot_o = quot;
  assign rem_o  = rem_full[3:0];

endmodule

>>> rtl/core/line_numbering_sectioner_unit.sv
// Line numbering sectioner: delimiter detection, numbering decision and prefix emission.
// Delimiter line: one newline word, loaded from S_NL into the output register once it is free.
// Unnumbered line: width plus one words from S_EMIT, one per cycle while the output is not stalled.
// A numbered line first passes S_MUL and then S_DIG for each digit, then emits as above.
// A line is accepted only when the previous one has loaded its last word; output stalls delay it.
// Reset (async, active low) loads register defaults and counter start; no clearing pass.
`include "line_numbering_sectioner_unit_macros.svh"

module line_numbering_sectioner_unit #(
  parameter int unsigned MAX_WIDTH = 63
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lnsu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lnsu_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  lnsu_in_if.sink                          in_i,
  lnsu_out_if.source                       out_o
);
  import lnsu_pkg::*;

  localparam int unsigned NDIG = (MAX_WIDTH < 10) ? MAX_WIDTH : 10;
  localparam int unsigned DW   = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int unsigned CW   = $clog2(NDIG + 1);
  localparam logic [5:0]  MAX_W = 6'(MAX_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIG,
    S_EMIT,
    S_NL
  } state_e;

  cfg_t        cfg;
  state_e      state_q;
  logic [31:0] line_counter_q;
  section_e    section_q;
  section_e    prev_delim_q;
  logic [15:0] blank_run_q;
  logic [31:0] v_q;
  logic [5:0]  w_q;
  logic [5:0]  pos_q;
  logic [CW-1:0] nd_q;
  logic        numbered_q;
  logic [3:0]  digits_q [NDIG];
  logic        out_valid_q;
  logic [7:0]  out_char_q;
  logic        drop_q;
  logic        last_q;

  logic        in_acc;
  logic        out_free;
  logic        load_out;
  logic [7:0]  d1;
  logic [7:0]  d2;
  logic        cont;
  logic        pair0;
  logic        is_hdr;
  logic        is_body;
  logic        is_ftr;
  logic        is_delim;
  section_e    delim_sec;
  logic        restart;
  logic [1:0]  mode_bits;
  logic        numbered;
  logic [15:0] br_inc;
  logic [15:0] blank_run_nx;
  logic [5:0]  w_clamp;
  logic [31:0] quot;
  logic [3:0]  rem;
  logic [CW-1:0] nd_next;
  logic        left_fmt;
  logic [5:0]  right_idx;
  logic [5:0]  left_idx;
  logic [5:0]  rd_idx;
  logic        in_num;
  logic [3:0]  rd_digit;
  logic [7:0]  emit_char;

  lnsu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lnsu_div10 u_div10 (
    .clk_i   (clk_i),
    .value_i (v_q),
    .quot_o  (quot),
    .rem_o   (rem)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign load_out   = ((state_q == S_EMIT) || (state_q == S_NL)) && out_free;

  assign out_o.valid        = out_valid_q;
  assign out_o.out_char     = out_char_q;
  assign out_o.drop_line    = drop_q;
  assign out_o.last_of_line = last_q;

  always_comb begin
    d1    = cfg.delimiter_pair[15:8];
    d2    = cfg.delimiter_pair[7:0];
    cont  = cfg.sep_flags[0];
    pair0 = (in_i.byte_zero == d1) && (in_i.byte_one == d2);
    is_hdr = pair0 && (in_i.byte_two == d1) && (in_i.byte_three == d2) &&
             (in_i.byte_four == d1) && (in_i.byte_five == d2) && (in_i.byte_six == CHAR_NL);
    is_body = pair0 && !is_hdr && (in_i.byte_two == d1) && (in_i.byte_three == d2) &&
              (in_i.byte_four == CHAR_NL);
    is_ftr = pair0 && !is_hdr && !is_body && (in_i.byte_two == CHAR_NL);
    is_delim = is_hdr || is_body || is_ftr;
    if (is_hdr) begin
      delim_sec = SEC_HEADER;
      restart   = !cont;
    end else if (is_body) begin
      delim_sec = SEC_BODY;
      restart   = !cont && (prev_delim_q != SEC_HEADER);
    end else begin
      delim_sec = SEC_FOOTER;
      restart   = !cont && (prev_delim_q == SEC_FOOTER);
    end
  end

  always_comb begin
    case (section_q)
      SEC_HEADER: mode_bits = cfg.section_modes[1:0];
      SEC_FOOTER: mode_bits = cfg.section_modes[5:4];
      default:    mode_bits = cfg.section_modes[3:2];
    endcase
    br_inc       = (blank_run_q == 16'hFFFF) ? blank_run_q : blank_run_q + 16'd1;
    blank_run_nx = blank_run_q;
    numbered     = 1'b0;
    case (mode_e'(mode_bits))
      MODE_NONBLANK: numbered = (in_i.byte_zero != CHAR_NL);
      MODE_ALL: begin
        if (in_i.byte_zero == CHAR_NL) begin
          if (br_inc == cfg.blank_group) begin
            blank_run_nx = 16'd0;
            numbered     = 1'b1;
          end else begin
            blank_run_nx = br_inc;
          end
        end else begin
          blank_run_nx = 16'd0;
          numbered     = 1'b1;
        end
      end
      MODE_PATTERN: numbered = in_i.pattern_match;
      default: numbered = 1'b0;
    endcase
    if (cfg.number_width == 6'd0) begin
      w_clamp = 6'd1;
    end else if (cfg.number_width > MAX_W) begin
      w_clamp = MAX_W;
    end else begin
      w_clamp = cfg.number_width;
    end
  end

  always_comb begin
    nd_next   = nd_q + CW'(1);
    left_fmt  = (format_e'(cfg.number_format) == FMT_LEFT);
    right_idx = w_q - 6'd1 - pos_q;
    left_idx  = 6'(nd_q) - 6'd1 - pos_q;
    rd_idx    = left_fmt ? left_idx : right_idx;
    in_num    = left_fmt ? (pos_q < 6'(nd_q)) : (right_idx < 6'(nd_q));
    rd_digit  = digits_q[rd_idx[DW-1:0]];
    if (!numbered_q) begin
      emit_char = CHAR_SPACE;
    end else if (pos_q == w_q) begin
      emit_char = cfg.sep_flags[8:1];
    end else if (in_num) begin
      emit_char = CHAR_ZERO + {4'd0, rd_digit};
    end else if (format_e'(cfg.number_format) == FMT_RIGHT_ZERO) begin
      emit_char = CHAR_ZERO;
    end else begin
      emit_char = CHAR_SPACE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DIG) begin
      digits_q[nd_q[DW-1:0]] <= rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      line_counter_q <= {1'b0, RST_START_VALUE};
      section_q      <= SEC_BODY;
      prev_delim_q   <= SEC_BODY;
      blank_run_q    <= 16'd0;
      v_q            <= 32'd0;
      w_q            <= RST_NUMBER_WIDTH;
      pos_q          <= 6'd0;
      nd_q           <= '0;
      numbered_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      out_char_q     <= 8'd0;
      drop_q         <= 1'b0;
      last_q         <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            w_q        <= w_clamp;
            pos_q      <= 6'd0;
            nd_q       <= '0;
            v_q        <= line_counter_q;
            numbered_q <= numbered && !is_delim;
            if (is_delim) begin
              section_q    <= delim_sec;
              prev_delim_q <= delim_sec;
              if (restart) begin
                line_counter_q <= {1'b0, cfg.start_value};
              end
              state_q <= S_NL;
            end else begin
              blank_run_q <= blank_run_nx;
              if (numbered) begin
                line_counter_q <= line_counter_q + {1'b0, cfg.step_value};
                state_q        <= S_MUL;
              end else begin
                state_q <= S_EMIT;
              end
            end
          end
        end
        S_MUL: state_q <= S_DIG;
        S_DIG: begin
          nd_q <= nd_next;
          v_q  <= quot;
          if ((quot == 32'd0) || (6'(nd_next) == w_q)) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_char_q  <= emit_char;
            drop_q      <= 1'b0;
            last_q      <= (pos_q == w_q);
            pos_q       <= pos_q + 6'd1;
            if (pos_q == w_q) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_NL: begin
          if (out_free) begin
            out_char_q  <= CHAR_NL;
            drop_q      <= 1'b1;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `LNSU_ASSERT_IMP(a_digits_fit, (state_q == S_EMIT), (6'(nd_q) <= w_q))
  `LNSU_ASSERT_IMP(a_drop_is_newline, (out_valid_q && drop_q),
                   (last_q && (out_char_q == CHAR_NL)))
  `LNSU_ASSERT_NXT(a_delim_to_newline, (in_acc && is_delim), (state_q == S_NL))

endmodule
